FILE: rtl/core/bnte_pkg.sv
package bnte_pkg;

   // alphabet store and block geometry
   localparam int AlphDepth = 85;
   localparam int AlphIdxW  = 7;
   localparam int BufW      = 40;
   localparam int MaxChars  = 8;

   // divide by 85: q = (w * Div85Mul) >> Div85Shift, exact for any 32-bit w
   localparam logic [31:0] Div85Mul   = 32'hC0C0C0C1;
   localparam int          Div85Shift = 38;
   localparam logic [31:0] Radix85    = 32'd85;

   // configuration register indexes
   localparam logic [1:0] REG_KIND = 2'd0;
   localparam logic [1:0] REG_PAD  = 2'd1;
   localparam logic [1:0] REG_ZGRP = 2'd2;

   typedef enum logic [1:0] {
      KIND_HEX = 2'd0,
      KIND_B32 = 2'd1,
      KIND_B64 = 2'd2,
      KIND_B85 = 2'd3
   } enc_kind_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic {
      BLD_IDLE = 1'b0,
      BLD_CONV = 1'b1
   } bld_state_type;

   // finished block or alphabet load, packer to builder
   typedef struct packed {
      op_type               op;
      logic                 last;
      logic [2:0]           nbytes;
      logic [BufW-1:0]      value;      // block left-justified, zero-filled
      logic [AlphIdxW-1:0]  alph_index;
      logic [7:0]           alph_char;
   } desc_type;

   // character job, builder to emitter
   typedef struct packed {
      op_type                           op;
      logic                             last;
      logic [3:0]                       count;     // characters in total
      logic [3:0]                       nsym;      // leading characters from the alphabet
      logic [6:0]                       lit_char;  // character for the rest
      logic [MaxChars-1:0][AlphIdxW-1:0] sym;
      logic [AlphIdxW-1:0]              alph_index;
      logic [7:0]                       alph_char;
   } job_type;

   function automatic logic [2:0] blk_bytes(enc_kind_type k);
      case (k)
         KIND_HEX: return 3'd1;
         KIND_B32: return 3'd5;
         KIND_B64: return 3'd3;
         default:  return 3'd4;
      endcase
   endfunction

   function automatic logic [3:0] blk_chars(enc_kind_type k);
      case (k)
         KIND_HEX: return 4'd2;
         KIND_B32: return 4'd8;
         KIND_B64: return 4'd4;
         default:  return 4'd5;
      endcase
   endfunction

   // symbols that cover nb bytes of a block
   function automatic logic [3:0] sym_count(enc_kind_type k, logic [2:0] nb);
      logic [3:0] n;
      case (k)
         KIND_HEX: n = 4'd2;
         KIND_B32: begin
            case (nb)
               3'd1:    n = 4'd2;
               3'd2:    n = 4'd4;
               3'd3:    n = 4'd5;
               3'd4:    n = 4'd7;
               default: n = 4'd8;
            endcase
         end
         KIND_B64: begin
            case (nb)
               3'd1:    n = 4'd2;
               3'd2:    n = 4'd3;
               default: n = 4'd4;
            endcase
         end
         default: n = (nb >= 3'd4) ? 4'd5 : ({1'b0, nb} + 4'd1);
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/core/bnte_packer.sv
module bnte_packer import bnte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  enc_kind_type        kind,
   input  logic                kind_wr,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic [AlphIdxW-1:0] req_alph_index,
   input  logic [7:0]          req_alph_char,
   output logic                desc_valid,
   output desc_type            desc,
   input  logic                desc_take
);

   logic [BufW-1:0] blk_ff, blk_in;
   logic [2:0]      fill_ff, fill_in;
   logic            desc_valid_ff, desc_valid_in;
   desc_type        desc_ff, desc_in;

   logic            accept;
   logic [BufW-1:0] blk_shift;
   logic [BufW-1:0] aligned;
   logic [2:0]      full;
   logic [2:0]      fill_inc;
   logic [2:0]      nb;
   logic            complete;

   // input transfer only when the descriptor slot is free or draining
   assign req_stall  = desc_valid_ff && !desc_take;
   assign accept     = req_valid && !req_stall;
   assign desc_valid = desc_valid_ff;
   assign desc       = desc_ff;

   // block assembly
   always_comb begin
      full      = blk_bytes(kind);
      blk_shift = {blk_ff[BufW-9:0], req_data_byte};
      fill_inc  = fill_ff + 3'd1;
      complete  = (fill_inc >= full) || req_last;
      nb        = (fill_inc > full) ? full : fill_inc;
      aligned   = blk_shift << {3'd5 - nb, 3'b000};
   end

   // next state
   always_comb begin
      blk_in        = blk_ff;
      fill_in       = fill_ff;
      desc_valid_in = desc_valid_ff && !desc_take;
      desc_in       = desc_ff;
      if (kind_wr) begin
         blk_in  = '0;
         fill_in = '0;
      end else if (accept) begin
         desc_in.op         = op_type'(req_op);
         desc_in.last       = req_last;
         desc_in.nbytes     = nb;
         desc_in.value      = aligned;
         desc_in.alph_index = req_alph_index;
         desc_in.alph_char  = req_alph_char;
         if (op_type'(req_op) == OP_LOAD) begin
            desc_valid_in = 1'b1;
         end else if (complete) begin
            desc_valid_in = 1'b1;
            blk_in        = '0;
            fill_in       = '0;
         end else begin
            blk_in  = blk_shift;
            fill_in = fill_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff        <= '0;
         fill_ff       <= '0;
         desc_valid_ff <= 1'b0;
      end else begin
         blk_ff        <= blk_in;
         fill_ff       <= fill_in;
         desc_valid_ff <= desc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   // open block never holds a whole block
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < blk_bytes(kind))
      else $error("open block fill reached block size");

endmodule

FILE: rtl/core/bnte_builder.sv
module bnte_builder import bnte_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  enc_kind_type kind,
   input  logic [6:0]   pad_char,
   input  logic [6:0]   zgrp_char,
   input  logic         desc_valid,
   input  desc_type     desc,
   output logic         desc_take,
   output logic         job_valid,
   output job_type      job,
   input  logic         job_take
);

   bld_state_type state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [63:0]   prod_ff, prod_in;
   logic [31:0]   cur_ff, cur_in;
   logic [3:0][AlphIdxW-1:0] dig_ff, dig_in;
   logic          conv_last_ff, conv_last_in;
   logic [2:0]    conv_nb_ff, conv_nb_in;
   logic          job_valid_ff, job_valid_in;
   job_type       job_ff, job_in;

   logic          job_free;
   logic [31:0]   w_desc;
   logic          zero_grp;
   logic          to_conv;
   logic [25:0]   q;
   logic [31:0]   rem;
   logic [AlphIdxW-1:0] digit;
   logic [31:0]   mul_a;
   logic [63:0]   product;
   logic          last_step;
   job_type       dj;
   job_type       bj;

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   // base85 digit unit: one reciprocal multiply per digit, least significant first
   always_comb begin
      job_free  = !job_valid_ff || job_take;
      w_desc    = desc.value[BufW-1:8];
      zero_grp  = (desc.nbytes == blk_bytes(kind)) && (w_desc == 32'd0) && (zgrp_char != 7'd0);
      to_conv   = (desc.op == OP_DATA) && (kind == KIND_B85) && !zero_grp;
      q         = prod_ff[63:Div85Shift];
      rem       = cur_ff - ({6'b0, q} * Radix85);
      digit     = rem[AlphIdxW-1:0];
      mul_a     = (state_ff == BLD_IDLE) ? w_desc : {6'b0, q};
      product   = 64'(mul_a) * 64'(Div85Mul);
      last_step = (step_ff == 3'd4);
   end

   // job for bit-slice kinds, loads and the zero group
   always_comb begin
      dj            = '0;
      dj.op         = desc.op;
      dj.last       = desc.last;
      dj.alph_index = desc.alph_index;
      dj.alph_char  = desc.alph_char;
      dj.nsym       = sym_count(kind, desc.nbytes);
      dj.count      = dj.nsym;
      dj.lit_char   = pad_char;
      if (kind == KIND_B85) begin
         dj.nsym     = 4'd0;
         dj.count    = 4'd1;
         dj.lit_char = zgrp_char;
      end else if ((pad_char != 7'd0) && (desc.nbytes != blk_bytes(kind)) &&
                   ((kind == KIND_B32) || (kind == KIND_B64))) begin
         dj.count = blk_chars(kind);
      end
      for (int i = 0; i < MaxChars; i++) begin
         case (kind)
            KIND_HEX: begin
               if (i < 2) dj.sym[i] = {3'b0, desc.value[BufW - 1 - 4*i -: 4]};
            end
            KIND_B32: dj.sym[i] = {2'b0, desc.value[BufW - 1 - 5*i -: 5]};
            KIND_B64: begin
               if (i < 4) dj.sym[i] = {1'b0, desc.value[BufW - 1 - 6*i -: 6]};
            end
            default: dj.sym[i] = '0;
         endcase
      end
   end

   // job for converted base85 digits, most significant first
   always_comb begin
      bj          = '0;
      bj.op       = OP_DATA;
      bj.last     = conv_last_ff;
      bj.nsym     = sym_count(KIND_B85, conv_nb_ff);
      bj.count    = bj.nsym;
      bj.lit_char = zgrp_char;
      bj.sym[0]   = digit;
      bj.sym[1]   = dig_ff[0];
      bj.sym[2]   = dig_ff[1];
      bj.sym[3]   = dig_ff[2];
      bj.sym[4]   = dig_ff[3];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BLD_IDLE: if (desc_valid && to_conv) state_in = BLD_CONV;
         BLD_CONV: if (last_step && job_free) state_in = BLD_IDLE;
         default:  state_in = BLD_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      desc_take    = 1'b0;
      job_valid_in = job_valid_ff && !job_take;
      job_in       = job_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      dig_in       = dig_ff;
      conv_last_in = conv_last_ff;
      conv_nb_in   = conv_nb_ff;
      case (state_ff)
         BLD_IDLE: begin
            if (desc_valid && to_conv) begin
               desc_take    = 1'b1;
               prod_in      = product;
               cur_in       = w_desc;
               step_in      = 3'd0;
               conv_last_in = desc.last;
               conv_nb_in   = desc.nbytes;
            end else if (desc_valid && job_free) begin
               desc_take    = 1'b1;
               job_valid_in = 1'b1;
               job_in       = dj;
            end
         end
         BLD_CONV: begin
            if (!last_step) begin
               prod_in                     = product;
               cur_in                      = {6'b0, q};
               dig_in[2'(3'd3 - step_ff)]  = digit;
               step_in                     = step_ff + 3'd1;
            end else if (job_free) begin
               job_valid_in = 1'b1;
               job_in       = bj;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BLD_IDLE;
         step_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      cur_ff       <= cur_in;
      dig_ff       <= dig_in;
      conv_last_ff <= conv_last_in;
      conv_nb_ff   <= conv_nb_in;
      job_ff       <= job_in;
   end

   // pending job is never overwritten
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_take |=> job_valid_ff && $stable(job_ff))
      else $error("pending job changed before transfer");

   // no descriptor taken while digits are in flight
   a_conv_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == BLD_CONV |-> !desc_take && step_ff <= 3'd4)
      else $error("descriptor taken during base85 conversion");

endmodule

FILE: rtl/core/bnte_emitter.sv
module bnte_emitter import bnte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   // alphabet store, one write and one registered read per cycle
   logic [7:0] alph_mem [AlphDepth];
   logic [7:0] rdata_ff;

   logic [2:0] ci_ff, ci_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_lit_ff, s1_last_ff;
   logic [6:0] s1_char_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;

   logic       o_free;
   logic       s1_move;
   logic       s1_free;
   logic       is_load;
   logic       is_final;
   logic       use_sym;
   logic       issue;
   logic       mem_we;
   logic       mem_re;
   logic [AlphIdxW-1:0] cur_sym;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // issue control: one character per cycle while the output is not stalled, loads in order with reads
   always_comb begin
      o_free   = !rsp_valid_ff || !rsp_stall;
      s1_move  = s1_valid_ff && o_free;
      s1_free  = !s1_valid_ff || o_free;
      is_load  = (job.op == OP_LOAD);
      is_final = ({1'b0, ci_ff} == (job.count - 4'd1));
      use_sym  = ({1'b0, ci_ff} < job.nsym);
      cur_sym  = job.sym[ci_ff];
      issue    = job_valid && !is_load && s1_free;
      mem_we   = job_valid && is_load && (job.alph_index < AlphIdxW'(AlphDepth));
      mem_re   = issue && use_sym;
      job_take = job_valid && (is_load || (s1_free && is_final));
   end

   always_ff @(posedge clock) begin
      if (mem_we) alph_mem[job.alph_index] <= job.alph_char;
      if (mem_re) rdata_ff <= alph_mem[cur_sym];
   end

   // next state
   always_comb begin
      ci_in        = ci_ff;
      if (issue) ci_in = is_final ? 3'd0 : ci_ff + 3'd1;
      s1_valid_in  = issue || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ci_ff        <= ci_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // read stage and output register payload
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_lit_ff  <= !use_sym;
         s1_char_ff <= job.lit_char;
         s1_last_ff <= job.last && is_final;
      end
      if (s1_move) begin
         rsp_char_ff <= s1_lit_ff ? {1'b0, s1_char_ff} : rdata_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   // a data job leaves only with its final character
   a_take_final: assert property (@(posedge clock) disable iff (reset)
      job_take && (job.op == OP_DATA) |-> issue && is_final)
      else $error("data job released before its final character");

   // read data held while the read stage waits
   a_rdata_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(rdata_ff))
      else $error("alphabet read data lost while stalled");

endmodule

FILE: rtl/core/base_n_text_encoder_unit.sv
// path: input transfer, packer descriptor register, builder job register, emitter read stage and
//   output register; a base85 group that is converted to digits passes the digit unit first
// throughput: one character per cycle at the output while rsp_stall is low; hex gives two characters
//   a byte, and the digit unit takes no new block until a base85 group is done (one multiply per digit)
// reset: synchronous; clears the configuration registers, open block and pipeline valids.
//   the alphabet store is not cleared and must be loaded before use
module base_n_text_encoder_unit import bnte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic [AlphIdxW-1:0] req_alph_index,
   input  logic [7:0]          req_alph_char,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_char
);

   enc_kind_type kind_ff, kind_in;
   logic [6:0]   pad_ff, pad_in;
   logic [6:0]   zgrp_ff, zgrp_in;
   logic         kind_wr;

   logic         desc_valid;
   desc_type     desc;
   logic         desc_take;
   logic         job_valid;
   job_type      job;
   logic         job_take;

   // configuration registers
   always_comb begin
      kind_wr = csr_wr_en && (csr_index == REG_KIND);
      kind_in = kind_ff;
      pad_in  = pad_ff;
      zgrp_in = zgrp_ff;
      if (kind_wr) kind_in = enc_kind_type'(csr_wdata[1:0]);
      if (csr_wr_en && (csr_index == REG_PAD)) pad_in = csr_wdata;
      if (csr_wr_en && (csr_index == REG_ZGRP)) zgrp_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_HEX;
         pad_ff  <= '0;
         zgrp_ff <= '0;
      end else begin
         kind_ff <= kind_in;
         pad_ff  <= pad_in;
         zgrp_ff <= zgrp_in;
      end
   end

   bnte_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .kind           (kind_ff),
      .kind_wr        (kind_wr),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .req_alph_index (req_alph_index),
      .req_alph_char  (req_alph_char),
      .desc_valid     (desc_valid),
      .desc           (desc),
      .desc_take      (desc_take)
   );

   bnte_builder u_builder (
      .clock      (clock),
      .reset      (reset),
      .kind       (kind_ff),
      .pad_char   (pad_ff),
      .zgrp_char  (zgrp_ff),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_take  (desc_take),
      .job_valid  (job_valid),
      .job        (job),
      .job_take   (job_take)
   );

   bnte_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_take      (job_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: dv/bnte_checker.sv
`timescale 1ns / 1ps

module bnte_checker import bnte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_wdata,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last,
   input  logic [AlphIdxW-1:0] req_alph_index,
   input  logic [7:0]          req_alph_char,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [7:0]          rsp_out_char,
   input  logic                rsp_last_char,
   output int unsigned         chars_pending,
   output int unsigned         mismatch_count
);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } enc_char_type;

   // encoder state as the block should hold it
   logic [7:0]   alphabet [AlphDepth];
   logic [39:0]  open_blk;
   logic [2:0]   open_fill;
   enc_kind_type cur_kind;
   logic [6:0]   pad_chr;
   logic [6:0]   zgrp_chr;
   enc_char_type chars_due [$];
   int unsigned  errs = 0;

   // add one message byte; a finished or closing group queues its characters
   task automatic encode_byte(input logic [7:0] data, input logic is_last);
      int unsigned  grp_bytes, sbits, full_chars, count, shift, nb, n, sym_idx, sym_mask;
      logic [39:0]  v;
      logic [31:0]  w;
      logic [7:0]   digit [5];
      logic [7:0]   txt [8];
      enc_char_type e;
      case (cur_kind)
         KIND_HEX: begin
            grp_bytes = 1; sbits = 4; full_chars = 2;
         end
         KIND_B32: begin
            grp_bytes = 5; sbits = 5; full_chars = 8;
         end
         KIND_B64: begin
            grp_bytes = 3; sbits = 6; full_chars = 4;
         end
         default: begin
            grp_bytes = 4; sbits = 0; full_chars = 5;
         end
      endcase
      open_blk  = {open_blk[31:0], data};
      open_fill = open_fill + 3'd1;
      if (open_fill >= grp_bytes || is_last) begin
         nb = (open_fill > grp_bytes) ? grp_bytes : open_fill;
         // left-justify the group, zero-filled on the right
         v  = open_blk << (8 * (grp_bytes - nb));
         n  = 0;
         if (cur_kind == KIND_B85) begin
            w = v[31:0];
            if (nb == grp_bytes && w == 32'd0 && zgrp_chr != 7'd0) begin
               txt[0] = {1'b0, zgrp_chr};
               n = 1;
            end else begin
               // radix-85 digits, most significant first
               for (int i = 4; i >= 0; i--) begin
                  digit[i] = alphabet[w % 85];
                  w = w / 85;
               end
               n = (nb == grp_bytes) ? 5 : nb + 1;
               for (int i = 0; i < n; i++) txt[i] = digit[i];
            end
         end else begin
            count    = (nb * 8 + sbits - 1) / sbits;
            shift    = grp_bytes * 8;
            sym_mask = (1 << sbits) - 1;
            for (int i = 0; i < count; i++) begin
               shift  -= sbits;
               sym_idx = 32'((v >> shift) & 40'(sym_mask));
               txt[n]  = alphabet[sym_idx];
               n++;
            end
            // pad a short base32/base64 tail to a whole group
            if (nb != grp_bytes && pad_chr != 7'd0 && cur_kind != KIND_HEX) begin
               while (n < full_chars) begin
                  txt[n] = {1'b0, pad_chr};
                  n++;
               end
            end
         end
         for (int i = 0; i < n; i++) begin
            e.ch   = txt[i];
            e.last = is_last && (i == n - 1);
            chars_due.push_back(e);
         end
         open_blk  = '0;
         open_fill = '0;
      end
   endtask

   // follow register writes and input transfers, compare output transfers
   always @(posedge clock) begin : track
      enc_char_type due;
      if (reset) begin
         open_blk  = '0;
         open_fill = '0;
         cur_kind  = KIND_HEX;
         pad_chr   = '0;
         zgrp_chr  = '0;
         chars_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_KIND: begin
                  cur_kind  = enc_kind_type'(csr_wdata[1:0]);
                  open_blk  = '0;
                  open_fill = '0;
               end
               REG_PAD:  pad_chr = csr_wdata;
               REG_ZGRP: zgrp_chr = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_LOAD) begin
               if (req_alph_index < AlphDepth) alphabet[req_alph_index] = req_alph_char;
            end else begin
               encode_byte(req_data_byte, req_last);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (chars_due.size() == 0) begin
               $error("unexpected transfer: out_char %h last_char %b",
                      rsp_out_char, rsp_last_char);
               errs++;
            end else begin
               due = chars_due.pop_front();
               if (rsp_out_char !== due.ch) begin
                  $error("out_char: expected %h, actual %h", due.ch, rsp_out_char);
                  errs++;
               end
               if (rsp_last_char !== due.last) begin
                  $error("last_char: expected %b, actual %b", due.last, rsp_last_char);
                  errs++;
               end
            end
         end
      end
      chars_pending  <= chars_due.size();
      mismatch_count <= errs;
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bnte_pkg::*;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned DrainCycles = 16;
   localparam int unsigned HoldCycles  = 300;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [1:0]          csr_index;
   logic [6:0]          csr_wdata;
   logic                req_valid;
   logic                req_stall;
   logic                req_op;
   logic [7:0]          req_data_byte;
   logic                req_last;
   logic [AlphIdxW-1:0] req_alph_index;
   logic [7:0]          req_alph_char;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_out_char;
   logic                rsp_last_char;
   int unsigned         chars_pending;
   int unsigned         mismatch_count;
   int unsigned         cycle_cnt;
   logic                pressure_on;
   logic                no_idle;

   base_n_text_encoder_unit i_dut (.*);

   bnte_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle stretch: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(6, 30);
   endfunction

   // output side stalls, with one long hold-off once pressure is armed
   initial begin : rsp_side
      int unsigned g;
      logic        held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (pressure_on && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            g = no_idle ? 0 : idle_len();
            if (g != 0) begin
               rsp_stall <= 1'b1;
               repeat (g) @(posedge clock);
               rsp_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // present one item after a random gap and hold it until the transfer
   task automatic offer(input op_type op, input logic [7:0] data, input logic last,
                        input logic [6:0] idx, input logic [7:0] chr);
      int unsigned g;
      g = no_idle ? 0 : idle_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_data_byte  <= data;
      req_last       <= last;
      req_alph_index <= idx;
      req_alph_char  <= chr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      offer(OP_DATA, b, last, 7'($urandom_range(0, 127)), 8'($urandom));
   endtask

   task automatic load_entry(input int unsigned idx, input logic [7:0] chr);
      offer(OP_LOAD, 8'($urandom), 1'($urandom), 7'(idx), chr);
   endtask

   // wait until every expected character is out and the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_regs(input enc_kind_type kind, input logic [6:0] pad,
                             input logic [6:0] zgrp);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= REG_KIND;
      csr_wdata <= {5'b0, kind};
      @(posedge clock);
      csr_index <= REG_PAD;
      csr_wdata <= pad;
      @(posedge clock);
      csr_index <= REG_ZGRP;
      csr_wdata <= zgrp;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random messages under one setting; the phase closes its last message
   task automatic run_phase(input enc_kind_type kind, input logic [6:0] pad,
                            input logic [6:0] zgrp, input int unsigned n_items,
                            input int unsigned zero_pct, input logic quiet,
                            input logic squeeze);
      logic [7:0] b;
      write_regs(kind, pad, zgrp);
      no_idle <= quiet;
      if (squeeze) pressure_on <= 1'b1;
      for (int unsigned k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 99) < 10 && k + 1 < n_items) begin
            load_entry($urandom_range(0, 127), 8'($urandom));
         end else begin
            if ($urandom_range(0, 99) < zero_pct) b = 8'h00;
            else if ($urandom_range(0, 9) == 0) b = 8'hFF;
            else b = 8'($urandom);
            send_byte(b, ($urandom_range(0, 7) == 0) || (k + 1 == n_items));
         end
      end
   endtask

   initial begin : watchdog
      cycle_cnt = 0;
      while (cycle_cnt < CycleLimit) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= REG_KIND;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_op         <= OP_DATA;
      req_data_byte  <= '0;
      req_last       <= 1'b0;
      req_alph_index <= '0;
      req_alph_char  <= '0;
      pressure_on    <= 1'b0;
      no_idle        <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every alphabet entry is written before any data transfer
      for (int i = 0; i < AlphDepth; i++)
         load_entry(i, (i == 0) ? 8'h00 : (i == AlphDepth - 1) ? 8'hFF : 8'($urandom));

      // hex ignores padding and zero group; loads past the table are dropped
      write_regs(KIND_HEX, 7'd126, 7'd127);
      send_byte(8'h00, 1'b0);
      load_entry(127, 8'hAA);
      load_entry(AlphDepth, 8'h55);
      send_byte(8'hFF, 1'b1);

      // base32: full group ending a message, then a padded tail with a load inside
      write_regs(KIND_B32, 7'd127, 7'd122);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      load_entry(3, 8'h5A);
      send_byte(8'h80, 1'b1);

      // base64 tail without padding; an open group is dropped by the kind write
      write_regs(KIND_B64, 7'd0, 7'd0);
      send_byte(8'h01, 1'b1);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hCD, 1'b0);

      // base85: zero group, all-ones group, short tail of zeros gives digits
      write_regs(KIND_B85, 7'd127, 7'd122);
      repeat (4) send_byte(8'h00, 1'b0);
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);

      // random messages across settings
      run_phase(KIND_HEX, 7'd0,   7'd0,   3,  10, 1'b0, 1'b0);
      run_phase(KIND_B32, 7'd61,  7'd0,   3,  10, 1'b0, 1'b0);
      run_phase(KIND_B32, 7'd0,   7'd127, 3,  10, 1'b1, 1'b0);
      run_phase(KIND_B64, 7'd127, 7'd0,   3,  10, 1'b0, 1'b0);
      run_phase(KIND_B64, 7'd0,   7'd0,   3,  10, 1'b0, 1'b0);
      run_phase(KIND_B85, 7'd0,   7'd122, 3,  60, 1'b0, 1'b0);
      run_phase(KIND_B85, 7'd1,   7'd127, 3,  60, 1'b1, 1'b0);
      run_phase(KIND_B32, 7'd61,  7'd122, 24, 10, 1'b0, 1'b1);
      run_phase(KIND_HEX, 7'd126, 7'd0,   3,  10, 1'b1, 1'b0);

      settle();
      if (mismatch_count == 0 && chars_pending == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule
